// ===== design/pte_pkg.sv =====
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and constants of the pixel twinkle engine.
// ----------------------------------------------------------------------------
package pte_pkg;

    // pixel count default and field widths
    localparam int PIXELS_DEF   = 64;
    localparam int PIX_W        = 6;
    localparam int LEVEL_W      = 8;
    localparam int DRAW_W       = 15;
    localparam int STEP_W       = 3;
    localparam int PHASE_W      = 2;
    localparam int CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd1;

    // register reset values
    localparam logic [LEVEL_W-1:0] FLOOR_RESET   = 8'd20;
    localparam logic [LEVEL_W-1:0] CEILING_RESET = 8'd180;

    // fixed offsets
    localparam logic [LEVEL_W-1:0] PEAK_MARGIN = 8'd15;
    localparam logic [STEP_W-1:0]  RATE_MOD    = 3'd5;

    // pixel phases
    localparam logic [PHASE_W-1:0] PH_LOW    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_BRIGHT = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DIM    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_HIGH   = 2'd3;

    // state held by one cell
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] current_level;
        logic [STEP_W-1:0]  step_size;
    } pix_state_t;

    // input beat
    typedef struct packed {
        logic [PIX_W-1:0]  pick_index;
        logic [DRAW_W-1:0] target_draw;
        logic [DRAW_W-1:0] rate_draw;
    } in_beat_t;

    // output beat
    typedef struct packed {
        logic [PIX_W-1:0]   pixel_number;
        logic [LEVEL_W-1:0] level;
        logic               frame_end;
    } out_beat_t;

    // pick request handed to the stepper
    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] peak;
        logic [STEP_W-1:0]  step_size;
    } pick_t;

endpackage

// ===== design/pte_cell.sv =====
// ----------------------------------------------------------------------------
// pte_cell
// One link of the pixel ring: holds the state of one pixel and takes the
// state of its neighbour whenever the ring shifts.
// ----------------------------------------------------------------------------
module pte_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  pte_pkg::pix_state_t d_in,
    output pte_pkg::pix_state_t q_out
);
    import pte_pkg::*;

    pix_state_t state_reg;
    pix_state_t state_next;

    // take the neighbour's state on a shift
    always_comb begin
        state_next = state_reg;
        if (shift_en) begin
            state_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_LOW;
            state_reg.peak          <= '0;
            state_reg.current_level <= FLOOR_RESET;
            state_reg.step_size     <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign q_out = state_reg;

endmodule

// ===== design/pte_divider.sv =====
// ----------------------------------------------------------------------------
// pte_divider
// Restoring remainder unit: one dividend bit a cycle for the target draw
// modulo the span; the rate draw modulo five is folded at the start.
// ----------------------------------------------------------------------------
module pte_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pte_pkg::DRAW_W-1:0]   target_draw,
    input  logic [pte_pkg::DRAW_W-1:0]   rate_draw,
    input  logic [pte_pkg::LEVEL_W-1:0]  span,
    output logic                         done,
    output logic [pte_pkg::LEVEL_W-1:0]  span_rem,
    output logic [pte_pkg::STEP_W-1:0]   rate_rem
);
    import pte_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W + 1);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DRAW_W - 1);
    localparam logic [4:0] MOD5_ONE = {2'b00, RATE_MOD};
    localparam logic [4:0] MOD5_TWO = {1'b0, RATE_MOD, 1'b0};

    logic                busy_reg,  busy_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [DRAW_W-1:0]   tdd_reg,   tdd_next;
    logic [LEVEL_W-1:0]  div_reg,   div_next;
    logic [LEVEL_W-1:0]  trem_reg,  trem_next;
    logic [STEP_W-1:0]   rrem_reg,  rrem_next;
    logic                done_reg,  done_next;

    logic [LEVEL_W:0]    t_trial;

    // rate draw modulo five by summing hex digits, sixteen leaving one
    function automatic logic [STEP_W-1:0] rate_mod5(input logic [DRAW_W-1:0] v);
        logic [5:0] fold1;
        logic [4:0] fold2;
        fold1 = {2'b00, v[3:0]} + {2'b00, v[7:4]} + {2'b00, v[11:8]}
              + {3'b000, v[14:12]};
        fold2 = {3'b000, fold1[5:4]} + {1'b0, fold1[3:0]};
        if (fold2 >= MOD5_TWO) begin
            fold2 = fold2 - MOD5_TWO;
        end
        if (fold2 >= MOD5_ONE) begin
            fold2 = fold2 - MOD5_ONE;
        end
        return fold2[STEP_W-1:0];
    endfunction

    // one restoring step per cycle on the span remainder
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        tdd_next  = tdd_reg;
        div_next  = div_reg;
        trem_next = trem_reg;
        rrem_next = rrem_reg;
        done_next = 1'b0;
        t_trial   = {trem_reg, tdd_reg[DRAW_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            tdd_next  = target_draw;
            div_next  = span;
            trem_next = '0;
            rrem_next = rate_mod5(rate_draw);
        end else if (busy_reg) begin
            tdd_next = {tdd_reg[DRAW_W-2:0], 1'b0};
            if (t_trial >= {1'b0, div_reg}) begin
                trem_next = LEVEL_W'(t_trial - {1'b0, div_reg});
            end else begin
                trem_next = t_trial[LEVEL_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        tdd_reg  <= tdd_next;
        div_reg  <= div_next;
        trem_reg <= trem_next;
        rrem_reg <= rrem_next;
    end

    assign done     = done_reg;
    assign span_rem = trem_reg;
    assign rate_rem = rrem_reg;

endmodule

// ===== design/pte_stepper.sv =====
// ----------------------------------------------------------------------------
// pte_stepper
// Per-pixel update at the head of the ring: applies a pending pick, then
// moves the brightness one frame along its phase.
// ----------------------------------------------------------------------------
module pte_stepper (
    input  pte_pkg::pix_state_t           st_in,
    input  pte_pkg::pick_t                pick,
    input  logic [pte_pkg::LEVEL_W-1:0]   floor_level,
    input  logic [pte_pkg::LEVEL_W-1:0]   ceiling_level,
    output pte_pkg::pix_state_t           st_out
);
    import pte_pkg::*;

    pix_state_t        ps;
    logic [LEVEL_W:0]  up_sum;
    logic signed [LEVEL_W+1:0] down_diff;
    logic [LEVEL_W-1:0] pk;

    always_comb begin
        // pick: start brightening from low, start dimming from high
        ps = st_in;
        if (pick.hit) begin
            if (st_in.phase == PH_LOW) begin
                ps.phase     = PH_BRIGHT;
                ps.peak      = pick.peak;
                ps.step_size = pick.step_size;
            end else if (st_in.phase == PH_HIGH) begin
                ps.phase = PH_DIM;
            end
        end

        // frame step
        st_out    = ps;
        pk        = (ps.peak > ceiling_level) ? ceiling_level : ps.peak;
        up_sum    = {1'b0, ps.current_level} + {6'd0, ps.step_size};
        down_diff = $signed({2'b00, ps.current_level}) - $signed({7'd0, ps.step_size});
        case (ps.phase)
            PH_LOW: begin
                st_out.current_level = floor_level;
            end
            PH_HIGH: begin
                if (ps.peak > ceiling_level) begin
                    st_out.peak          = ceiling_level;
                    st_out.current_level = ceiling_level;
                end
            end
            PH_BRIGHT: begin
                st_out.peak = pk;
                if (ps.current_level < pk) begin
                    if (up_sum > {1'b0, pk}) begin
                        st_out.current_level = pk;
                    end else begin
                        st_out.current_level = up_sum[LEVEL_W-1:0];
                    end
                end else begin
                    st_out.current_level = pk;
                    st_out.phase         = PH_HIGH;
                end
            end
            default: begin
                if (ps.current_level > floor_level) begin
                    if (down_diff < $signed({2'b00, floor_level})) begin
                        st_out.current_level = floor_level;
                    end else begin
                        st_out.current_level = down_diff[LEVEL_W-1:0];
                    end
                end else begin
                    st_out.current_level = floor_level;
                    st_out.phase         = PH_LOW;
                end
            end
        endcase
    end

endmodule

// ===== design/pixel_twinkle_engine.sv =====
// ----------------------------------------------------------------------------
// pixel_twinkle_engine
// Frame-tick twinkle engine over a ring of pixel cells.
// ----------------------------------------------------------------------------
// Each input beat is one frame tick and produces PIXELS output beats, pixel 0
// first, frame_end set on the last. A tick runs from the accept through the
// remainder unit, which works out the target draw modulo the span one dividend
// bit per cycle, then the load of the peak and step for the picked pixel, then
// the sweep, one output beat per cycle as the cell ring rotates through the
// stepper; back-pressure on the output pauses the sweep. A new tick is taken
// once the last beat of the previous frame sits in the output register.
// Registers: index 0 floor_level, index 1 ceiling_level; other indexes are
// ignored.
module pixel_twinkle_engine #(
    parameter int PIXELS = pte_pkg::PIXELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pte_pkg::in_beat_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pte_pkg::out_beat_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pte_pkg::LEVEL_W-1:0]   cfg_data
);
    import pte_pkg::*;

    localparam int CNT_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [CNT_W-1:0] LAST_PIX = CNT_W'(PIXELS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]          state_reg,   state_next;
    logic [CNT_W-1:0]    pix_cnt_reg, pix_cnt_next;
    logic [LEVEL_W-1:0]  floor_reg,   floor_next;
    logic [LEVEL_W-1:0]  ceil_reg,    ceil_next;
    logic [PIX_W-1:0]    pick_idx_reg, pick_idx_next;
    logic [LEVEL_W-1:0]  pick_peak_reg, pick_peak_next;
    logic [STEP_W-1:0]   pick_step_reg, pick_step_next;
    logic                m_valid_reg, m_valid_next;
    out_beat_t           m_data_reg,  m_data_next;

    logic                s_accept;
    logic                advance;
    logic                div_done;
    logic [LEVEL_W-1:0]  span_rem;
    logic [STEP_W-1:0]   rate_rem;
    logic signed [LEVEL_W+1:0] span_s;
    logic                span_pos;
    logic [LEVEL_W:0]    base_sum;
    logic [LEVEL_W:0]    rem_sum;
    pick_t               pick;
    pix_state_t          head_new;
    pix_state_t          cell_q [PIXELS];

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign advance   = (state_reg == ST_SWEEP) && (!m_valid_reg || m_ready);

    // span and peak arithmetic from the registers
    assign span_s   = $signed({2'b00, ceil_reg}) - $signed({2'b00, floor_reg})
                    - $signed({2'b00, PEAK_MARGIN});
    assign span_pos = !span_s[LEVEL_W+1] && (span_s != '0);
    assign base_sum = {1'b0, floor_reg} + {1'b0, PEAK_MARGIN};
    assign rem_sum  = base_sum + {1'b0, span_rem};

    // remainder unit
    pte_divider u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_accept),
        .target_draw (s_data.target_draw),
        .rate_draw   (s_data.rate_draw),
        .span        (span_s[LEVEL_W-1:0]),
        .done        (div_done),
        .span_rem    (span_rem),
        .rate_rem    (rate_rem)
    );

    // head stepper
    assign pick.hit       = (pick_idx_reg == PIX_W'(pix_cnt_reg));
    assign pick.peak      = pick_peak_reg;
    assign pick.step_size = pick_step_reg;

    pte_stepper u_step (
        .st_in         (cell_q[0]),
        .pick          (pick),
        .floor_level   (floor_reg),
        .ceiling_level (ceil_reg),
        .st_out        (head_new)
    );

    // ring of cells, head at cell 0, stepped state re-enters at the tail
    for (genvar k = 0; k < PIXELS; k++) begin : g_cell
        pix_state_t d_in;
        if (k == PIXELS - 1) begin : g_tail
            assign d_in = head_new;
        end else begin : g_body
            assign d_in = cell_q[k+1];
        end
        pte_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (advance),
            .d_in     (d_in),
            .q_out    (cell_q[k])
        );
    end

    // control sequence and output register
    always_comb begin
        state_next     = state_reg;
        pix_cnt_next   = pix_cnt_reg;
        floor_next     = floor_reg;
        ceil_next      = ceil_reg;
        pick_idx_next  = pick_idx_reg;
        pick_peak_next = pick_peak_reg;
        pick_step_next = pick_step_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FLOOR:   floor_next = cfg_data;
                REG_CEILING: ceil_next  = cfg_data;
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pick_idx_next = s_data.pick_index;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (span_pos) begin
                        pick_peak_next = rem_sum[LEVEL_W-1:0];
                    end else if (base_sum[LEVEL_W]) begin
                        pick_peak_next = '1;
                    end else begin
                        pick_peak_next = base_sum[LEVEL_W-1:0];
                    end
                    pick_step_next = rate_rem + 1'b1;
                    pix_cnt_next   = '0;
                    state_next     = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (advance) begin
                    m_valid_next            = 1'b1;
                    m_data_next.pixel_number = PIX_W'(pix_cnt_reg);
                    m_data_next.level        = head_new.current_level;
                    m_data_next.frame_end    = (pix_cnt_reg == LAST_PIX);
                    pix_cnt_next             = pix_cnt_reg + 1'b1;
                    if (pix_cnt_reg == LAST_PIX) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pix_cnt_reg <= '0;
            floor_reg   <= FLOOR_RESET;
            ceil_reg    <= CEILING_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pix_cnt_reg <= pix_cnt_next;
            floor_reg   <= floor_next;
            ceil_reg    <= ceil_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pick_idx_reg  <= pick_idx_next;
        pick_peak_reg <= pick_peak_next;
        pick_step_reg <= pick_step_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel twinkle engine. A mirror of the pixel
// state works out the 64 brightness beats of every accepted frame tick and
// the result side compares each beat field by field, in order. Directed
// ticks cover draw extremes, every step size, the full twinkle cycle, empty
// spans, register changes and a long result hold-off; random phases then run
// at several level settings with random stalls and idle pauses.
// ----------------------------------------------------------------------------
module tb_top;

    import pte_pkg::*;

    localparam int NPIX         = PIXELS_DEF;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_SETTLE = 8;
    localparam int SHOW_FAULTS  = 10;
    localparam int RUN_LIMIT_NS = 20_000_000;
    localparam int DRAW_MAX     = (1 << DRAW_W) - 1;

    // indexes the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_beat_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_beat_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;

    // mirror of the pixel ring and the level registers
    logic [PHASE_W-1:0] ph_mirror    [NPIX];
    logic [LEVEL_W-1:0] peak_mirror  [NPIX];
    logic [LEVEL_W-1:0] level_mirror [NPIX];
    logic [STEP_W-1:0]  step_mirror  [NPIX];
    logic [LEVEL_W-1:0] floor_mirror;
    logic [LEVEL_W-1:0] ceil_mirror;

    // brightness beats still to come, oldest first
    out_beat_t pixel_levels_q [$];

    int tx_gap_max;
    int rx_stall_max;
    int sink_hold_cycles;
    int fault_count;
    int ticks_sent;
    int beats_seen;
    int reg_writes;

    pixel_twinkle_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #(HALF_PERIOD) aclk = ~aclk;

    // pick handling then one step of every pixel, queuing its beat
    function automatic void twinkle_tick(input in_beat_t b);
        int        p;
        int        span;
        int        tgt;
        int        lv;
        int        pk;
        int        st;
        int        fl;
        int        cl;
        out_beat_t r;
        p  = int'(b.pick_index);
        fl = int'(floor_mirror);
        cl = int'(ceil_mirror);
        if (p < NPIX) begin
            if (ph_mirror[p] == PH_LOW) begin
                span = cl - fl - int'(PEAK_MARGIN);
                if (span > 0) begin
                    tgt = int'(b.target_draw) % span + fl + int'(PEAK_MARGIN);
                end else begin
                    tgt = fl + int'(PEAK_MARGIN);
                end
                if (tgt > 255) begin
                    tgt = 255;
                end
                ph_mirror[p]   = PH_BRIGHT;
                peak_mirror[p] = LEVEL_W'(tgt);
                step_mirror[p] = STEP_W'(int'(b.rate_draw) % int'(RATE_MOD) + 1);
            end else if (ph_mirror[p] == PH_HIGH) begin
                ph_mirror[p] = PH_DIM;
            end
        end
        for (int i = 0; i < NPIX; i++) begin
            lv = int'(level_mirror[i]);
            pk = int'(peak_mirror[i]);
            st = int'(step_mirror[i]);
            case (ph_mirror[i])
                PH_LOW: begin
                    lv = fl;
                end
                PH_HIGH: begin
                    if (pk > cl) begin
                        pk = cl;
                        lv = cl;
                    end
                end
                PH_BRIGHT: begin
                    if (pk > cl) begin
                        pk = cl;
                    end
                    if (lv < pk) begin
                        lv = lv + st;
                        if (lv > pk) begin
                            lv = pk;
                        end
                    end else begin
                        lv = pk;
                        ph_mirror[i] = PH_HIGH;
                    end
                end
                default: begin
                    if (lv > fl) begin
                        lv = lv - st;
                        if (lv < fl) begin
                            lv = fl;
                        end
                    end else begin
                        lv = fl;
                        ph_mirror[i] = PH_LOW;
                    end
                end
            endcase
            if (lv < 0) begin
                lv = 0;
            end
            if (lv > 255) begin
                lv = 255;
            end
            level_mirror[i] = LEVEL_W'(lv);
            peak_mirror[i]  = LEVEL_W'(pk);
            r.pixel_number  = PIX_W'(i);
            r.level         = LEVEL_W'(lv);
            r.frame_end     = (i == NPIX - 1);
            pixel_levels_q.push_back(r);
        end
    endfunction

    function automatic in_beat_t make_tick(input int pick, input int tdraw, input int rdraw);
        in_beat_t b;
        b.pick_index  = PIX_W'(pick);
        b.target_draw = DRAW_W'(tdraw);
        b.rate_draw   = DRAW_W'(rdraw);
        return b;
    endfunction

    // offer one frame tick after a random gap; valid stays up after the beat
    task automatic send_tick(input in_beat_t b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        twinkle_tick(b);
        ticks_sent++;
    endtask

    // stop offering and wait until every queued beat has arrived
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pixel_levels_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    // one register write, only while the engine is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_FLOOR) begin
            floor_mirror = val;
        end else if (idx == REG_CEILING) begin
            ceil_mirror = val;
        end
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_levels(input int fl, input int cl);
        write_reg(REG_FLOOR, LEVEL_W'(fl));
        write_reg(REG_CEILING, LEVEL_W'(cl));
    endtask

    // reset levels, draw extremes, pick of a pixel already brightening
    task automatic test_reset_levels();
        send_tick(make_tick(0, 0, 0));
        send_tick(make_tick(NPIX - 1, DRAW_MAX, DRAW_MAX));
        send_tick(make_tick(0, DRAW_MAX, 3));
        wait_drained();
    endtask

    // narrow span so twinkles run brighten, high, dim and low in a few ticks
    task automatic test_full_twinkle();
        set_levels(20, 40);
        for (int k = 0; k < 12; k++) begin
            send_tick(make_tick(10 + (k % 4), k * 2731, k));
        end
        wait_drained();
    endtask

    // registers changed under pixels that are lit or dimming
    task automatic test_level_change();
        write_reg(REG_CEILING, 8'd30);
        send_tick(make_tick(11, 100, 2));
        write_reg(REG_FLOOR, 8'd28);
        send_tick(make_tick(12, 200, 4));
        send_tick(make_tick(13, 300, 1));
        wait_drained();
    endtask

    // span of zero or less, saturated peak, widest span, ignored indexes
    task automatic test_empty_span();
        set_levels(200, 210);
        send_tick(make_tick(20, 1234, 0));
        set_levels(250, 255);
        send_tick(make_tick(21, DRAW_MAX, 1));
        set_levels(255, 0);
        send_tick(make_tick(22, 0, 2));
        set_levels(0, 255);
        write_reg(REG_SPARE2, 8'hFF);
        write_reg(REG_SPARE3, 8'hAA);
        send_tick(make_tick(23, DRAW_MAX, DRAW_MAX));
        wait_drained();
    endtask

    // result side held off for a long stretch while ticks keep coming
    task automatic test_backpressure();
        set_levels(int'(FLOOR_RESET), int'(CEILING_RESET));
        tx_gap_max       = 0;
        sink_hold_cycles = 600;
        for (int k = 0; k < 6; k++) begin
            send_tick(make_tick($urandom_range(0, NPIX - 1), $urandom_range(0, DRAW_MAX),
                                $urandom_range(0, DRAW_MAX)));
        end
        wait_drained();
        tx_gap_max = 15;
    endtask

    // one random phase; most picks land on low or high pixels to keep twinkles moving
    task automatic run_random_phase(input int n, input int fl, input int cl);
        int cand [$];
        int pick;
        int td;
        int rd;
        set_levels(fl, cl);
        for (int k = 0; k < n; k++) begin
            cand.delete();
            for (int i = 0; i < NPIX; i++) begin
                if (ph_mirror[i] == PH_LOW || ph_mirror[i] == PH_HIGH) begin
                    cand.push_back(i);
                end
            end
            if (cand.size() != 0 && $urandom_range(0, 3) != 0) begin
                pick = cand[$urandom_range(0, cand.size() - 1)];
            end else begin
                pick = $urandom_range(0, NPIX - 1);
            end
            case ($urandom_range(0, 7))
                0:       td = 0;
                1:       td = DRAW_MAX;
                default: td = $urandom_range(0, DRAW_MAX);
            endcase
            rd = ($urandom_range(0, 7) == 0) ? DRAW_MAX : $urandom_range(0, DRAW_MAX);
            send_tick(make_tick(pick, td, rd));
        end
        wait_drained();
    endtask

    task automatic test_random();
        int fls [7] = '{20, 0, 10, 100, 245, 0, 0};
        int cls [7] = '{180, 255, 60, 130, 250, 0, 0};
        fls[5] = $urandom_range(0, 255);
        cls[5] = $urandom_range(0, 255);
        fls[6] = $urandom_range(0, 120);
        cls[6] = $urandom_range(fls[6], 255);
        for (int ph = 0; ph < 7; ph++) begin
            // every third phase runs with no idling on either side
            tx_gap_max   = (ph % 3 == 1) ? 0 : 15;
            rx_stall_max = (ph % 3 == 1) ? 0 : 15;
            run_random_phase(22, fls[ph], cls[ph]);
        end
        tx_gap_max   = 15;
        rx_stall_max = 15;
    endtask

    // result side: random stall per beat, or a long hold when asked
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (sink_hold_cycles > 0) begin
                stall            = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // compare every accepted beat with the oldest queued one
    always @(posedge aclk) begin : level_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (pixel_levels_q.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_FAULTS) begin
                    $display("unexpected beat: pixel %0d level %0d frame_end %0b",
                             m_data.pixel_number, m_data.level, m_data.frame_end);
                end
            end else begin
                want = pixel_levels_q.pop_front();
                if (m_data.pixel_number !== want.pixel_number || m_data.level !== want.level
                    || m_data.frame_end !== want.frame_end) begin
                    fault_count++;
                    if (fault_count <= SHOW_FAULTS) begin
                        $display("mismatch: want pixel %0d level %0d end %0b,",
                                 want.pixel_number, want.level, want.frame_end);
                        $display("          got pixel %0d level %0d end %0b",
                                 m_data.pixel_number, m_data.level, m_data.frame_end);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        tx_gap_max       = 15;
        rx_stall_max     = 15;
        sink_hold_cycles = 0;
        fault_count      = 0;
        ticks_sent       = 0;
        beats_seen       = 0;
        reg_writes       = 0;
        floor_mirror     = FLOOR_RESET;
        ceil_mirror      = CEILING_RESET;
        for (int i = 0; i < NPIX; i++) begin
            ph_mirror[i]    = PH_LOW;
            peak_mirror[i]  = '0;
            level_mirror[i] = FLOOR_RESET;
            step_mirror[i]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_levels();
        test_full_twinkle();
        test_level_change();
        test_empty_span();
        test_backpressure();
        test_random();

        wait_drained();
        $display("ran %0d frame ticks, %0d brightness beats, %0d register writes",
                 ticks_sent, beats_seen, reg_writes);
        $display("covered full twinkles, empty spans, level changes, long hold-off; %0d faults",
                 fault_count);
        if (fault_count == 0 && pixel_levels_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
